@@ src/scde_pkg.sv @@
// Package for the sample clock drift estimator: opcodes, register indexes,
// constants and the request and response structs shared by the top level and the divider.
`default_nettype none
package scde_pkg;
	localparam int unsigned DataWidth = 64;
	localparam logic [1:0] OpSetAnchor   = 2'd0;
	localparam logic [1:0] OpShiftAnchor = 2'd1;
	localparam logic [1:0] OpDriftQuery  = 2'd2;
	localparam logic [1:0] OpFrameQuery  = 2'd3;
	localparam logic RegTickRate   = 1'b0;
	localparam logic RegSampleRate = 1'b1;
	localparam logic [63:0] AllOnes   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SignBit   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] IntMax    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PpbScale  = 64'd1000000000;
	localparam logic [63:0] Q32One    = 64'h0000_0001_0000_0000;
	localparam logic [31:0] TickRateReset   = 32'd10000000;
	localparam logic [19:0] SampleRateReset = 20'd48000;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} sdiv_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [63:0] q;
		logic [63:0] rem;
	} sdiv_rsp_t;
endpackage
`default_nettype wire

@@ src/scde_scale_div.sv @@
// Bit-serial unit for floor(a*b/d): shift-add multiply, then restoring divide.
// Depends on scde_pkg.
`default_nettype none
module scde_scale_div import scde_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sdiv_req_t req,
	output sdiv_rsp_t      rsp
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} sdiv_state_t;

	sdiv_state_t state_q;
	logic [6:0]   cnt_q;
	logic [63:0]  mcand_q;
	logic [63:0]  mplier_q;
	logic [127:0] prod_q;
	logic [63:0]  d_q;
	logic [63:0]  r_q;
	logic [63:0]  lo_q;
	logic [63:0]  q_q;
	logic         ovf_q;

	logic [64:0]  r_sh;
	logic [64:0]  r_sub;
	logic [127:0] prod_add;

	// One multiplier bit per cycle, from the top, so the product shifts left.
	assign prod_add = {prod_q[126:0], 1'b0} + (mplier_q[63] ? {64'd0, mcand_q} : 128'd0);
	assign r_sh     = {r_q, lo_q[63]};
	assign r_sub    = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64 || d_q == '0 || ovf_q) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mcand_q  <= req.a;
				mplier_q <= req.b;
				d_q      <= req.d;
				prod_q   <= '0;
				q_q      <= '0;
				ovf_q    <= 1'b0;
			end
			S_MUL: begin
				prod_q   <= prod_add;
				mplier_q <= {mplier_q[62:0], 1'b0};
				if (cnt_q == 7'd63) begin
					r_q   <= prod_add[127:64];
					lo_q  <= prod_add[63:0];
					ovf_q <= prod_add[127:64] >= d_q;
				end
			end
			S_DIV: begin
				if (cnt_q != 7'd64 && d_q != '0 && !ovf_q) begin
					lo_q <= {lo_q[62:0], 1'b0};
					if (r_sh[64] || !r_sub[64]) begin
						r_q <= r_sub[63:0];
						q_q <= {q_q[62:0], 1'b1};
					end else begin
						r_q <= r_sh[63:0];
						q_q <= {q_q[62:0], 1'b0};
					end
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_comb begin
		rsp.done = state_q == S_DONE;
		rsp.ovf  = ovf_q && d_q != '0;
		if (d_q == '0) begin
			rsp.q   = '0;
			rsp.rem = '0;
		end else if (ovf_q) begin
			rsp.q   = AllOnes;
			rsp.rem = '0;
		end else begin
			rsp.q   = q_q;
			rsp.rem = r_q;
		end
	end

`ifndef ASSERT_OFF
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("divider done held longer than one cycle");
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (cnt_q <= 7'd63))
		else $error("multiply count ran past 63");
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.start) |=> (state_q == S_MUL))
		else $error("divider did not start");
`endif
endmodule
`default_nettype wire

@@ src/sample_clock_drift_estimator_unit.sv @@
// Top level of the sample clock drift estimator: anchor state, registers and
// the op sequencer. Depends on scde_pkg and scde_scale_div.
`default_nettype none
// A command is taken when start is high and busy is low. Set and shift anchor
// give no result and never raise busy. A frame query runs one scale divide
// and a drift query runs up to three, one after another, on a single
// bit-serial unit. Each divide loads its operands, runs 64 multiply steps,
// then the restoring divide steps, and hands back the quotient; the divide
// steps are skipped when the divisor is zero or the quotient overflows. Busy
// stays high from the sequencer state before the first divide through the
// output state. The result appears on the output ports for exactly one cycle
// with done high; the receiver cannot stall it.
module sample_clock_drift_estimator_unit import scde_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [63:0] tick_value,
	input  wire logic [63:0] frame_count,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic signed [63:0] nominal_frames,
	output logic signed [63:0] frame_error,
	output logic signed [63:0] drift_ppb,
	output logic [63:0]      ratio_q32,
	output logic [63:0]      frame_time,
	output logic             is_anchored
);
	typedef enum logic [6:0] {
		T_IDLE   = 7'b0000001,
		T_EXP    = 7'b0000010,
		T_PPB    = 7'b0000100,
		T_RATIO  = 7'b0001000,
		T_FRAME  = 7'b0010000,
		T_WAIT   = 7'b0100000,
		T_OUT    = 7'b1000000
	} top_state_t;

	top_state_t  state_q, after_q;
	logic [31:0] tick_rate_q;
	logic [19:0] audio_rate_q;
	logic [63:0] anchor_q;
	logic        anchored_q;
	logic [63:0] tv_q, fc_q;
	logic        neg_q, sneg_q;
	logic [63:0] exp_q, ppb_q, ratio_q, ftime_q;
	logic        is_drift_q;
	logic        req_start_q;
	logic [63:0] req_a_q, req_b_q, req_d_q;
	sdiv_req_t   req;
	sdiv_rsp_t   rsp;

	logic [63:0] mag, delta, surplus, smag, exp_sat, ppb_sat, ticks;
	logic        neg;

	assign req = '{start: req_start_q, a: req_a_q, b: req_b_q, d: req_d_q};

	scde_scale_div u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		neg = tv_q < anchor_q;
		if (neg) mag = (anchor_q - tv_q > SignBit) ? SignBit : anchor_q - tv_q;
		else     mag = (tv_q - anchor_q > IntMax) ? IntMax : tv_q - anchor_q;
		delta   = exp_q - fc_q;
		surplus = (delta == SignBit) ? IntMax : 64'd0 - delta;
		smag    = surplus[63] ? 64'd0 - surplus : surplus;
		if (!neg_q)             exp_sat = (rsp.q > IntMax) ? IntMax : rsp.q;
		else if (rsp.q >= SignBit) exp_sat = SignBit;
		else                    exp_sat = 64'd0 - rsp.q;
		if (!sneg_q)            ppb_sat = (rsp.q > IntMax) ? IntMax : rsp.q;
		else if (rsp.q >= SignBit) ppb_sat = SignBit;
		else                    ppb_sat = 64'd0 - rsp.q;
		ticks = (rsp.rem != '0 && rsp.q != AllOnes) ? rsp.q + 64'd1 : rsp.q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			after_q       <= T_IDLE;
			tick_rate_q   <= TickRateReset;
			audio_rate_q  <= SampleRateReset;
			anchor_q      <= '0;
			anchored_q    <= 1'b0;
			req_start_q   <= 1'b0;
		end else begin
			req_start_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == RegTickRate) tick_rate_q <= cfg_data;
				else audio_rate_q <= cfg_data[19:0];
			end
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						unique case (opcode)
							OpSetAnchor: begin
								anchor_q   <= tick_value;
								anchored_q <= 1'b1;
							end
							OpShiftAnchor: if (anchored_q) anchor_q <= anchor_q + tick_value;
							OpDriftQuery: state_q <= T_EXP;
							OpFrameQuery: state_q <= T_FRAME;
							default: ;
						endcase
					end
				end
				T_EXP: begin
					req_start_q <= 1'b1;
					state_q     <= T_WAIT;
					after_q     <= T_PPB;
				end
				T_PPB: begin
					if (exp_q != '0 && !exp_q[63]) begin
						req_start_q <= 1'b1;
						state_q     <= T_WAIT;
						after_q     <= T_RATIO;
					end else state_q <= T_OUT;
				end
				T_RATIO: begin
					if (!fc_q[63]) begin
						req_start_q <= 1'b1;
						state_q     <= T_WAIT;
						after_q     <= T_OUT;
					end else state_q <= T_OUT;
				end
				T_FRAME: begin
					req_start_q <= 1'b1;
					state_q     <= T_WAIT;
					after_q     <= T_OUT;
				end
				T_WAIT: if (rsp.done) state_q <= after_q;
				T_OUT: state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && start) begin
			tv_q       <= tick_value;
			fc_q       <= frame_count;
			is_drift_q <= opcode == OpDriftQuery;
			exp_q      <= '0;
			ppb_q      <= '0;
			ratio_q    <= Q32One;
			ftime_q    <= '0;
		end
		unique case (state_q)
			T_EXP: begin
				neg_q   <= neg;
				req_a_q <= mag;
				req_b_q <= {44'd0, audio_rate_q};
				req_d_q <= {32'd0, tick_rate_q};
			end
			T_PPB: begin
				sneg_q  <= surplus[63];
				req_a_q <= smag;
				req_b_q <= PpbScale;
				req_d_q <= exp_q;
			end
			T_RATIO: begin
				req_a_q <= fc_q;
				req_b_q <= Q32One;
				req_d_q <= exp_q;
			end
			T_FRAME: begin
				req_a_q <= fc_q;
				req_b_q <= {32'd0, tick_rate_q};
				req_d_q <= {44'd0, audio_rate_q};
			end
			T_WAIT: begin
				if (rsp.done) begin
					unique case (after_q)
						T_PPB:   exp_q   <= (req_d_q == '0) ? 64'd0 : exp_sat;
						T_RATIO: ppb_q   <= ppb_sat;
						T_OUT:   begin
							if (is_drift_q) ratio_q <= rsp.q;
							else if (req_d_q != '0) ftime_q <= anchor_q + ticks;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign busy            = state_q != T_IDLE;
	assign done            = state_q == T_OUT;
	assign nominal_frames  = is_drift_q ? exp_q : 64'd0;
	assign frame_error     = is_drift_q ? exp_q - fc_q : 64'd0;
	assign drift_ppb       = is_drift_q ? ppb_q : 64'd0;
	assign ratio_q32       = is_drift_q ? ratio_q : 64'd0;
	assign frame_time      = is_drift_q ? 64'd0 : ftime_q;
	assign is_anchored     = anchored_q;

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat held more than one cycle");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OpSetAnchor || opcode == OpShiftAnchor)) |=> !busy)
		else $error("anchor op left the sequencer busy");
`endif
endmodule
`default_nettype wire

@@ bench/sample_clock_drift_estimator_unit_tb.sv @@
// Self-checking bench for the sample clock drift estimator: random and directed
// commands, a bit-exact predictor and an in-order scoreboard of query results.
// Depends on scde_pkg and the sample_clock_drift_estimator_unit RTL.
`timescale 1ns / 100ps

typedef struct {
	logic [63:0] nominal_frames;
	logic [63:0] frame_error;
	logic [63:0] drift_ppb;
	logic [63:0] ratio_q32;
	logic [63:0] frame_time;
	logic        is_anchored;
} drift_result_t;

class drift_scoreboard;
	logic [63:0] anchor;
	logic        anchored;
	logic [31:0] tick_rate;
	logic [19:0] audio_rate;
	drift_result_t pending[$];
	int errors;

	function void clear();
		anchor = '0;
		anchored = 1'b0;
		tick_rate = scde_pkg::TickRateReset;
		audio_rate = scde_pkg::SampleRateReset;
		errors = 0;
	endfunction

	function void set_reg(logic idx, logic [31:0] val);
		if (idx == scde_pkg::RegTickRate) tick_rate = val;
		else audio_rate = val[19:0];
	endfunction

	// Exact floor(a*b/d); zero divisor gives 0, a quotient past 64 bits all ones.
	function logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] d,
			output logic [63:0] rem);
		logic [127:0] prod;
		logic [127:0] quo;
		prod = {64'd0, a} * {64'd0, b};
		rem = '0;
		if (d == 0) return '0;
		quo = prod / {64'd0, d};
		if (quo[127:64] != 0) return scde_pkg::AllOnes;
		rem = 64'(prod % {64'd0, d});
		return quo[63:0];
	endfunction

	function logic [63:0] signed_mul_div(logic neg, logic [63:0] mag, logic [63:0] b,
			logic [63:0] d);
		logic [63:0] q;
		logic [63:0] rem;
		q = mul_div(mag, b, d, rem);
		if (!neg) return (q > scde_pkg::IntMax) ? scde_pkg::IntMax : q;
		if (q >= scde_pkg::SignBit) return scde_pkg::SignBit;
		return -q;
	endfunction

	function void note_command(logic [1:0] op, logic [63:0] tv, logic [63:0] fc);
		drift_result_t r;
		logic neg;
		logic sneg;
		logic [63:0] mag;
		logic [63:0] surplus;
		logic [63:0] smag;
		logic [63:0] rem;
		logic [63:0] ticks;
		if (op == scde_pkg::OpSetAnchor) begin
			anchor = tv;
			anchored = 1'b1;
			return;
		end
		if (op == scde_pkg::OpShiftAnchor) begin
			if (anchored) anchor = anchor + tv;
			return;
		end
		r = '{default: '0};
		r.is_anchored = anchored;
		if (op == scde_pkg::OpDriftQuery) begin
			r.ratio_q32 = scde_pkg::Q32One;
			if (tick_rate != 0) begin
				neg = tv < anchor;
				if (neg) begin
					mag = anchor - tv;
					if (mag > scde_pkg::SignBit) mag = scde_pkg::SignBit;
				end else begin
					mag = tv - anchor;
					if (mag > scde_pkg::IntMax) mag = scde_pkg::IntMax;
				end
				r.nominal_frames = signed_mul_div(neg, mag, 64'(audio_rate),
					64'(tick_rate));
			end
			r.frame_error = r.nominal_frames - fc;
			if (r.nominal_frames != 0 && !r.nominal_frames[63]) begin
				surplus = (r.frame_error == scde_pkg::SignBit) ? scde_pkg::IntMax
					: -r.frame_error;
				sneg = surplus[63];
				smag = sneg ? -surplus : surplus;
				r.drift_ppb = signed_mul_div(sneg, smag, scde_pkg::PpbScale,
					r.nominal_frames);
				if (!fc[63])
					r.ratio_q32 = mul_div(fc, scde_pkg::Q32One, r.nominal_frames, rem);
			end
		end else if (audio_rate != 0) begin
			ticks = mul_div(fc, 64'(tick_rate), 64'(audio_rate), rem);
			if (rem != 0 && ticks != scde_pkg::AllOnes) ticks = ticks + 1;
			r.frame_time = anchor + ticks;
		end
		pending.push_back(r);
	endfunction

	function void report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endfunction

	function void check_result(drift_result_t got);
		drift_result_t want;
		if (pending.size() == 0) begin
			$display("unexpected result beat at %0t", $realtime);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.nominal_frames !== want.nominal_frames)
			report("nominal_frames", got.nominal_frames, want.nominal_frames);
		if (got.frame_error !== want.frame_error)
			report("frame_error", got.frame_error, want.frame_error);
		if (got.drift_ppb !== want.drift_ppb)
			report("drift_ppb", got.drift_ppb, want.drift_ppb);
		if (got.ratio_q32 !== want.ratio_q32)
			report("ratio_q32", got.ratio_q32, want.ratio_q32);
		if (got.frame_time !== want.frame_time)
			report("frame_time", got.frame_time, want.frame_time);
		if (got.is_anchored !== want.is_anchored)
			report("is_anchored", 64'(got.is_anchored), 64'(want.is_anchored));
	endfunction
endclass

module sample_clock_drift_estimator_unit_tb;
	import scde_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [63:0] tick_value;
	logic [63:0] frame_count;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic signed [63:0] nominal_frames;
	logic signed [63:0] frame_error;
	logic signed [63:0] drift_ppb;
	logic [63:0] ratio_q32;
	logic [63:0] frame_time;
	logic        is_anchored;

	drift_scoreboard sb;
	int gap_pct;

	sample_clock_drift_estimator_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .tick_value(tick_value), .frame_count(frame_count),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .nominal_frames(nominal_frames), .frame_error(frame_error),
		.drift_ppb(drift_ppb), .ratio_q32(ratio_q32), .frame_time(frame_time),
		.is_anchored(is_anchored)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		drift_result_t got;
		if (arst_n && done) begin
			got.nominal_frames = nominal_frames;
			got.frame_error = frame_error;
			got.drift_ppb = drift_ppb;
			got.ratio_q32 = ratio_q32;
			got.frame_time = frame_time;
			got.is_anchored = is_anchored;
			sb.check_result(got);
		end
	end

	// One command beat; start is held until the block takes it and stays high
	// into the next command unless the sender idles.
	task automatic send_command(logic [1:0] op, logic [63:0] tv, logic [63:0] fc);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		tick_value <= tv;
		frame_count <= fc;
		do @(posedge clk); while (busy);
		sb.note_command(op, tv, fc);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		// Set and shift give no result, so let any command in flight settle.
		repeat (500) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(5))
			0: v = v & 64'hFFFF;
			1: v = v & 64'hFFFF_FFFF;
			2: v = AllOnes - (v & 64'hFF);
			3: v = SignBit + (v & 64'hFF) - 64'd128;
			default: ;
		endcase
		return v;
	endfunction

	// Queries near the anchor so expected frames land in a useful range.
	task automatic random_command();
		logic [1:0] op;
		logic [63:0] tv;
		logic [63:0] fc;
		logic [63:0] expct;
		int pick;
		pick = $urandom_range(99);
		op = (pick < 10) ? OpSetAnchor : (pick < 20) ? OpShiftAnchor
			: (pick < 65) ? OpDriftQuery : OpFrameQuery;
		tv = rand64();
		fc = rand64();
		if (op == OpShiftAnchor && $urandom_range(1)) tv = 64'($signed($urandom_range(2000)))
			- 64'd1000;
		if (op == OpDriftQuery && $urandom_range(3) != 0) begin
			tv = sb.anchor + 64'($urandom()) * 64'($urandom_range(1, 4000));
			expct = sb.tick_rate == 0 ? 64'd0 : 64'(({64'd0, tv - sb.anchor}
				* 128'(sb.audio_rate)) / 128'(sb.tick_rate));
			fc = expct + 64'($signed($urandom_range(2000))) - 64'd1000;
		end
		if (op == OpFrameQuery && $urandom_range(1)) fc = 64'($urandom());
		send_command(op, tv, fc);
	endtask

	initial begin
		sb = new();
		sb.clear();
		gap_pct = 0;
		start = 1'b0;
		opcode = OpSetAnchor;
		tick_value = '0;
		frame_count = '0;
		cfg_we = 1'b0;
		cfg_index = RegTickRate;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries before any anchor, and a shift that must be ignored.
		send_command(OpDriftQuery, 64'd10000000, 64'd48000);
		send_command(OpShiftAnchor, 64'd5, '0);
		send_command(OpFrameQuery, '0, 64'd1);
		send_command(OpSetAnchor, 64'd1000, '0);
		send_command(OpDriftQuery, 64'd10001000, 64'd48010);
		send_command(OpDriftQuery, 64'd0, 64'd5);
		send_command(OpDriftQuery, AllOnes, AllOnes);
		send_command(OpDriftQuery, 64'd10001000, SignBit);
		send_command(OpDriftQuery, 64'd1000, '0);
		send_command(OpShiftAnchor, AllOnes, '0);
		send_command(OpFrameQuery, '0, AllOnes);
		send_command(OpFrameQuery, AllOnes, 64'd7);
		send_command(OpSetAnchor, SignBit, '0);
		send_command(OpDriftQuery, '0, '0);
		send_command(OpDriftQuery, AllOnes, 64'd3);
		write_reg(RegTickRate, '0);
		send_command(OpDriftQuery, 64'd123456, 64'd9);
		send_command(OpFrameQuery, '0, 64'd100);
		write_reg(RegSampleRate, '0);
		send_command(OpFrameQuery, '0, 64'd100);
		write_reg(RegTickRate, 32'hFFFF_FFFF);
		write_reg(RegSampleRate, 32'h000F_FFFF);
		send_command(OpSetAnchor, '0, '0);
		send_command(OpDriftQuery, IntMax, 64'd1);
		send_command(OpFrameQuery, '0, AllOnes);
		write_reg(RegTickRate, 32'd1);
		send_command(OpDriftQuery, AllOnes, 64'd2);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					write_reg(RegTickRate, 32'd10000000);
					write_reg(RegSampleRate, 32'd48000);
				end
				1: begin
					write_reg(RegTickRate, $urandom());
					write_reg(RegSampleRate, $urandom_range(1, 20'hFFFFF));
				end
				2: begin
					write_reg(RegTickRate, $urandom_range(1, 100));
					write_reg(RegSampleRate, 32'h000F_FFFF);
				end
				default: begin
					write_reg(RegTickRate, 32'hFFFF_FFFF);
					write_reg(RegSampleRate, $urandom_range(1, 1000));
				end
			endcase
			gap_pct = (phase < 3) ? 33 : (phase < 6) ? 52 : 0;
			for (int i = 0; i < 200; i++) random_command();
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
